>>> rtl/core/bresenham_line_rasterizer_defines.svh
// ----------------------------------------------------------------------------
// Line rasterizer assertion macros
// Shared concurrent checks for the rasterizer core.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("blr check failed");

// next-cycle implication, disabled in reset
`define BLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("blr check failed");

`endif

>>> rtl/core/blr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Widths, register map, item kinds and the structs passed between stages.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int COORD_BITS = 16;
    localparam int COLOR_W    = 24;
    localparam int ADDR_W     = 27;
    localparam int FW_W       = 13;
    localparam int BPP_W      = 4;
    localparam int PITCH_W    = 16;

    localparam int DX_W  = COORD_BITS + 1;
    localparam int NDY_W = COORD_BITS + 2;
    localparam int ERR_W = COORD_BITS + 3;
    localparam int E2_W  = ERR_W + 1;

    localparam int VCMP_W = COORD_BITS + FW_W;
    localparam int PY_W   = COORD_BITS + PITCH_W;
    localparam int PX_W   = COORD_BITS + BPP_W;
    localparam int SUM_W  = ((PY_W + 1) > ADDR_W) ? (PY_W + 1) : ADDR_W;

    localparam int IN_RAW_W   = 4 * COORD_BITS + COLOR_W;
    localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = 2 * COORD_BITS + 1 + ADDR_W + COLOR_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [FW_W-1:0]    FRAME_WIDTH_RST  = FW_W'(1024);
    localparam logic [FW_W-1:0]    FRAME_HEIGHT_RST = FW_W'(1024);
    localparam logic [BPP_W-1:0]   BPP_RST          = BPP_W'(4);
    localparam logic [PITCH_W-1:0] PITCH_RST        = PITCH_W'(4096);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BYTES_PER_PX = 2'd2,
        REG_ROW_PITCH    = 2'd3
    } reg_idx_t;

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_ADVANCE = 1'b1
    } kind_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [FW_W-1:0]    frame_width;
        logic [FW_W-1:0]    frame_height;
        logic [BPP_W-1:0]   bytes_per_pixel;
        logic [PITCH_W-1:0] row_pitch;
    } cfg_t;

    // classified command, line set-up already worked out for loads
    typedef struct packed {
        kind_t                    kind;
        coord_t                   x0;
        coord_t                   y0;
        coord_t                   x1;
        coord_t                   y1;
        logic [DX_W-1:0]          dx;
        logic signed [NDY_W-1:0]  ndy;
        logic                     sxn;
        logic                     syn;
        logic signed [ERR_W-1:0]  err;
        logic [COLOR_W-1:0]       color;
    } cmd_t;

    typedef struct packed {
        coord_t             x;
        coord_t             y;
        logic               vis;
        logic               last;
        logic [COLOR_W-1:0] color;
    } pix_t;

endpackage

>>> rtl/core/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// All-octant line walker with clipping and framebuffer addressing.
//
//   port group   dir   carries
//   s_*          in    load / advance items (tuser = kind)
//   m_*          out   pixel items (tlast = final pixel of the line)
//   p*           in/out APB register access
//
// One item per clock in and out while the output is not stalled; the walker's
// error update is combinational, so it sets the rate.
// After its item is taken, a pixel passes the input register, queue,
// walker, product stage and output register.
// Synchronous active-low reset; no line is active after reset.
// Output stalls back up through the stages; the queue keeps the input
// side taking items until it fills while the output register holds a pixel.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: x_start, y_start, x_end, y_end, line_color
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [blr_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: kind
    input  logic                           s_tuser,
    // tdata: pixel_x, pixel_y, visible, byte_address, pixel_color, zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [blr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [blr_pkg::PADDR_W-1:0]    paddr,
    input  logic [blr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [blr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import blr_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    logic     f_valid, f_ready;
    cmd_t     f_cmd;
    logic     q_valid, q_ready;
    cmd_t     q_cmd;
    logic     p_valid, p_ready;
    pix_t     p_pix;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_FRAME_WIDTH:  cfg_next.frame_width     = pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height    = pwdata[FW_W-1:0];
                REG_BYTES_PER_PX: cfg_next.bytes_per_pixel = pwdata[BPP_W-1:0];
                REG_ROW_PITCH:    cfg_next.row_pitch       = pwdata[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(cfg_reg.frame_height);
            REG_BYTES_PER_PX: prdata = CFG_DATA_W'(cfg_reg.bytes_per_pixel);
            REG_ROW_PITCH:    prdata = CFG_DATA_W'(cfg_reg.row_pitch);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width     <= FRAME_WIDTH_RST;
            cfg_reg.frame_height    <= FRAME_HEIGHT_RST;
            cfg_reg.bytes_per_pixel <= BPP_RST;
            cfg_reg.row_pitch       <= PITCH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    blr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    blr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    blr_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .pix_valid (p_valid),
        .pix_ready (p_ready),
        .pix       (p_pix)
    );

    blr_addr u_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pix_valid (p_valid),
        .pix_ready (p_ready),
        .pix       (p_pix),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> rtl/core/blr_front.sv
// ----------------------------------------------------------------------------
// Line rasterizer front end
// Registers input items, decodes the kind and precomputes line set-up.
// ----------------------------------------------------------------------------
module blr_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [blr_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output blr_pkg::cmd_t                cmd
);
    import blr_pkg::*;

    logic   valid_reg, valid_next;
    cmd_t   cmd_reg, cmd_next;
    coord_t x0, y0, x1, y1;
    logic [DX_W-1:0]         dx;
    logic signed [NDY_W-1:0] ndy;
    logic                    take;

    assign x0 = coord_t'(s_tdata[COORD_BITS-1:0]);
    assign y0 = coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
    assign x1 = coord_t'(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
    assign y1 = coord_t'(s_tdata[4*COORD_BITS-1:3*COORD_BITS]);

    assign s_tready = !valid_reg || cmd_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        if (x1 > x0) begin
            dx = DX_W'(x1) - DX_W'(x0);
        end else begin
            dx = DX_W'(x0) - DX_W'(x1);
        end
        if (y1 > y0) begin
            ndy = NDY_W'(y0) - NDY_W'(y1);
        end else begin
            ndy = NDY_W'(y1) - NDY_W'(y0);
        end
    end

    always_comb begin
        cmd_next       = cmd_reg;
        cmd_next.kind  = kind_t'(s_tuser);
        cmd_next.x0    = x0;
        cmd_next.y0    = y0;
        cmd_next.x1    = x1;
        cmd_next.y1    = y1;
        cmd_next.dx    = dx;
        cmd_next.ndy   = ndy;
        cmd_next.sxn   = !(x0 < x1);
        cmd_next.syn   = !(y0 < y1);
        cmd_next.err   = $signed(ERR_W'({1'b0, dx})) + ERR_W'(ndy);
        cmd_next.color = s_tdata[4*COORD_BITS +: COLOR_W];
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

>>> rtl/core/blr_queue.sv
// ----------------------------------------------------------------------------
// Line rasterizer command queue
// Short show-ahead queue between the front end and the walker.
// ----------------------------------------------------------------------------
`include "bresenham_line_rasterizer_defines.svh"

module blr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  blr_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output blr_pkg::cmd_t pop_cmd
);
    import blr_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

    `BLR_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= QCNT_W'(QUEUE_DEPTH))
    `BLR_ASSERT_NEXT(a_cnt_track, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)
    `BLR_ASSERT_IMP(a_ptr_gap, aclk, aresetn, cnt_reg == '0, wptr_reg == rptr_reg)

endmodule

>>> rtl/core/blr_walk.sv
// ----------------------------------------------------------------------------
// Line rasterizer walker
// Holds the line state and steps one pixel per load or per advance on an active line, with clipping.
// ----------------------------------------------------------------------------
`include "bresenham_line_rasterizer_defines.svh"

module blr_walk (
    input  logic          aclk,
    input  logic          aresetn,
    input  blr_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  blr_pkg::cmd_t cmd,
    output logic          pix_valid,
    input  logic          pix_ready,
    output blr_pkg::pix_t pix
);
    import blr_pkg::*;

    coord_t                  cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    coord_t                  end_x_reg, end_y_reg;
    logic [DX_W-1:0]         dx_reg;
    logic signed [NDY_W-1:0] ndy_reg;
    logic                    sxn_reg, syn_reg;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [COLOR_W-1:0]      color_reg;
    logic                    active_reg, active_next;
    logic                    pv_reg, pv_next;
    pix_t                    pix_reg, pix_next;

    // working copy: the command's set-up on a load, else the held line
    coord_t                  w_x, w_y, w_ex, w_ey;
    logic [DX_W-1:0]         w_dx;
    logic signed [NDY_W-1:0] w_ndy;
    logic                    w_sxn, w_syn;
    logic signed [ERR_W-1:0] w_err;
    logic [COLOR_W-1:0]      w_color;

    logic signed [E2_W-1:0]  e2;
    logic                    is_load, emit, pop;
    logic                    do_x, do_y, brk_x, brk_y, brk, step_x, step_y;

    assign is_load   = (cmd.kind == KIND_LOAD);
    assign cmd_ready = !pv_reg || pix_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign emit      = is_load || active_reg;

    always_comb begin
        if (is_load) begin
            w_x     = cmd.x0;
            w_y     = cmd.y0;
            w_ex    = cmd.x1;
            w_ey    = cmd.y1;
            w_dx    = cmd.dx;
            w_ndy   = cmd.ndy;
            w_sxn   = cmd.sxn;
            w_syn   = cmd.syn;
            w_err   = cmd.err;
            w_color = cmd.color;
        end else begin
            w_x     = cur_x_reg;
            w_y     = cur_y_reg;
            w_ex    = end_x_reg;
            w_ey    = end_y_reg;
            w_dx    = dx_reg;
            w_ndy   = ndy_reg;
            w_sxn   = sxn_reg;
            w_syn   = syn_reg;
            w_err   = err_reg;
            w_color = color_reg;
        end
    end

    always_comb begin
        e2     = $signed({w_err, 1'b0});
        do_x   = e2 >= E2_W'(w_ndy);
        do_y   = e2 <= $signed(E2_W'({1'b0, w_dx}));
        brk_x  = do_x && (w_x == w_ex);
        brk_y  = !brk_x && do_y && (w_y == w_ey);
        brk    = brk_x || brk_y;
        step_x = do_x && !brk_x;
        step_y = !brk_x && do_y && !brk_y;

        err_next = w_err;
        if (step_x && step_y) begin
            err_next = w_err + ERR_W'(w_ndy) + $signed(ERR_W'({1'b0, w_dx}));
        end else if (step_x) begin
            err_next = w_err + ERR_W'(w_ndy);
        end else if (step_y) begin
            err_next = w_err + $signed(ERR_W'({1'b0, w_dx}));
        end

        cur_x_next = w_x;
        if (step_x) begin
            cur_x_next = w_sxn ? w_x - 1'b1 : w_x + 1'b1;
        end
        cur_y_next = w_y;
        if (step_y) begin
            cur_y_next = w_syn ? w_y - 1'b1 : w_y + 1'b1;
        end
        active_next = !brk;
    end

    always_comb begin
        pix_next.x     = w_x;
        pix_next.y     = w_y;
        pix_next.vis   = !w_x[COORD_BITS-1] && !w_y[COORD_BITS-1]
                      && (VCMP_W'($unsigned(w_x)) < VCMP_W'(cfg.frame_width))
                      && (VCMP_W'($unsigned(w_y)) < VCMP_W'(cfg.frame_height));
        pix_next.last  = brk;
        pix_next.color = w_color;

        pv_next = pv_reg;
        if (pop) begin
            pv_next = emit;
        end else if (pix_ready) begin
            pv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            pv_reg     <= 1'b0;
        end else begin
            pv_reg <= pv_next;
            if (pop && emit) begin
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            end_x_reg <= w_ex;
            end_y_reg <= w_ey;
            dx_reg    <= w_dx;
            ndy_reg   <= w_ndy;
            sxn_reg   <= w_sxn;
            syn_reg   <= w_syn;
            err_reg   <= err_next;
            color_reg <= w_color;
            pix_reg   <= pix_next;
        end
    end

    assign pix_valid = pv_reg;
    assign pix       = pix_reg;

    `BLR_ASSERT_NEXT(a_last_ends, aclk, aresetn, pop && emit && brk, !active_reg)
    `BLR_ASSERT_NEXT(a_pop_emits, aclk, aresetn, pop, pv_reg == $past(emit))
    `BLR_ASSERT_NEXT(a_idle_drop, aclk, aresetn, pop && !is_load && !active_reg, !active_reg)

endmodule

>>> rtl/core/blr_addr.sv
// ----------------------------------------------------------------------------
// Line rasterizer address stage
// Framebuffer byte address in two steps: products, then sum and output item.
// ----------------------------------------------------------------------------
module blr_addr (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  blr_pkg::cfg_t                  cfg,
    input  logic                           pix_valid,
    output logic                           pix_ready,
    input  blr_pkg::pix_t                  pix,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [blr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import blr_pkg::*;

    logic              a_valid_reg, a_valid_next;
    pix_t              a_pix_reg;
    logic [PY_W-1:0]   py_reg;
    logic [PX_W-1:0]   px_reg;
    logic              a_ready;

    logic              o_valid_reg, o_valid_next;
    pix_t              o_pix_reg;
    logic [ADDR_W-1:0] o_addr_reg, addr_next;
    logic [SUM_W-1:0]  sum;

    assign a_ready   = !o_valid_reg || m_tready;
    assign pix_ready = !a_valid_reg || a_ready;

    // clipped pixels carry a zero address
    assign sum       = SUM_W'(py_reg) + SUM_W'(px_reg);
    assign addr_next = a_pix_reg.vis ? sum[ADDR_W-1:0] : '0;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (pix_ready) begin
            a_valid_next = pix_valid;
        end
        o_valid_next = o_valid_reg;
        if (a_ready) begin
            o_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_ready && pix_valid) begin
            a_pix_reg <= pix;
            py_reg    <= PY_W'($unsigned(pix.y)) * PY_W'(cfg.row_pitch);
            px_reg    <= PX_W'($unsigned(pix.x)) * PX_W'(cfg.bytes_per_pixel);
        end
        if (a_ready && a_valid_reg) begin
            o_pix_reg  <= a_pix_reg;
            o_addr_reg <= addr_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tlast  = o_pix_reg.last;
    assign m_tdata  = OUT_DATA_W'({o_pix_reg.color, o_addr_reg, o_pix_reg.vis,
                                   o_pix_reg.y, o_pix_reg.x});

endmodule

>>> bench/tb_bresenham_line_rasterizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Feeds load and advance items through the stream input and checks every
// pixel against a behavioural line walker kept in step with accepted items.
// Covers all octants, clipping against several frame settings, addressing
// wrap, lines reloaded mid-walk, advances with no line, random gaps on both
// sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_bresenham_line_rasterizer;
    import blr_pkg::*;

    localparam int LONG_HOLD = 300;
    localparam int SETTLE    = 10;

    typedef struct {
        kind_t              kind;
        coord_t             xs;
        coord_t             ys;
        coord_t             xe;
        coord_t             ye;
        logic [COLOR_W-1:0] color;
    } line_item_t;

    typedef struct {
        coord_t             x;
        coord_t             y;
        logic               vis;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata  = '0;
    logic                    s_tuser  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    m_tlast;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [PADDR_W-1:0]      paddr    = '0;
    logic [CFG_DATA_W-1:0]   pwdata   = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    bresenham_line_rasterizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // frame settings as the block should hold them
    logic [FW_W-1:0]    frame_w    = FRAME_WIDTH_RST;
    logic [FW_W-1:0]    frame_h    = FRAME_HEIGHT_RST;
    logic [BPP_W-1:0]   px_bytes   = BPP_RST;
    logic [PITCH_W-1:0] pitch      = PITCH_RST;

    // walker state
    coord_t                  walk_x, walk_y, stop_x, stop_y;
    logic [DX_W-1:0]         span_x;
    logic signed [NDY_W-1:0] span_ny;
    logic                    dir_xn, dir_yn;
    logic signed [ERR_W-1:0] err_acc;
    logic [COLOR_W-1:0]      line_color;
    bit                      line_on = 0;

    line_item_t pending_items[$];
    pixel_t     pixels_due[$];
    line_item_t offered;

    int  src_gap, snk_gap, hold_cnt;
    int  hold_reqs, holds_done;
    bit  quiet;
    int  errors, reported;
    int  n_loads, n_advances, n_idle_adv, n_pixels, n_clipped, n_ends;
    int  phase_items;

    // next pixel of the current line, then one walker step
    task automatic emit_pixel();
        pixel_t p;
        longint x, y, e2;
        bit     brk;
        x = longint'(walk_x);
        y = longint'(walk_y);
        p.x     = walk_x;
        p.y     = walk_y;
        p.vis   = x >= 0 && x < longint'(frame_w) && y >= 0 && y < longint'(frame_h);
        p.addr  = p.vis ? ADDR_W'(y * longint'(pitch) + x * longint'(px_bytes)) : '0;
        p.color = line_color;
        e2  = 2 * longint'(err_acc);
        brk = 0;
        if (e2 >= longint'(span_ny)) begin
            if (walk_x == stop_x) begin
                brk = 1;
            end else begin
                err_acc = ERR_W'(longint'(err_acc) + longint'(span_ny));
                walk_x  = dir_xn ? coord_t'(walk_x - 1) : coord_t'(walk_x + 1);
            end
        end
        if (!brk && e2 <= longint'(span_x)) begin
            if (walk_y == stop_y) begin
                brk = 1;
            end else begin
                err_acc = ERR_W'(longint'(err_acc) + longint'(span_x));
                walk_y  = dir_yn ? coord_t'(walk_y - 1) : coord_t'(walk_y + 1);
            end
        end
        if (brk) line_on = 0;
        p.last = brk;
        n_pixels++;
        if (!p.vis) n_clipped++;
        if (brk) n_ends++;
        pixels_due.push_back(p);
    endtask

    task automatic walk_item(input line_item_t it);
        longint x0, y0, x1, y1, dx, ndy;
        if (it.kind == KIND_LOAD) begin
            x0 = longint'(it.xs);
            y0 = longint'(it.ys);
            x1 = longint'(it.xe);
            y1 = longint'(it.ye);
            dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
            ndy = (y1 > y0) ? y0 - y1 : y1 - y0;
            walk_x     = it.xs;
            walk_y     = it.ys;
            stop_x     = it.xe;
            stop_y     = it.ye;
            span_x     = DX_W'(dx);
            span_ny    = NDY_W'(ndy);
            dir_xn     = !(x0 < x1);
            dir_yn     = !(y0 < y1);
            err_acc    = ERR_W'(dx + ndy);
            line_color = it.color;
            line_on    = 1;
            n_loads++;
            emit_pixel();
        end else begin
            n_advances++;
            if (line_on) emit_pixel();
            else n_idle_adv++;
        end
    endtask

    // stream driver
    always @(posedge aclk) begin : drive_proc
        bit offer;
        offer = 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) walk_item(offered);
            if (!(s_tvalid && !s_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_items.size() > 0) begin
                    if (!quiet && $urandom_range(0, 15) == 0) begin
                        src_gap = $urandom_range(0, 17);
                    end else begin
                        offered = pending_items.pop_front();
                        offer   = 1;
                    end
                end
                s_tvalid <= offer;
                if (offer) begin
                    s_tdata <= {offered.color, offered.ye, offered.xe, offered.ys, offered.xs};
                    s_tuser <= offered.kind;
                end
            end
        end
    end

    // pixel monitor and receiver stalls
    always @(posedge aclk) begin : pixel_mon
        pixel_t got, want;
        bit     rdy;
        if (aresetn && m_tvalid && m_tready) begin
            got.x     = m_tdata[15:0];
            got.y     = m_tdata[31:16];
            got.vis   = m_tdata[32];
            got.addr  = m_tdata[59:33];
            got.color = m_tdata[83:60];
            got.last  = m_tlast;
            if (pixels_due.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("pixel with none due: x=%0d y=%0d", got.x, got.y);
                end
            end else begin
                want = pixels_due.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.vis !== want.vis ||
                    got.addr !== want.addr || got.color !== want.color ||
                    got.last !== want.last) begin
                    errors++;
                    if (reported < 10) begin
                        reported++;
                        $display("mismatch exp x=%0d y=%0d vis=%0b addr=%h col=%h last=%0b",
                                 want.x, want.y, want.vis, want.addr, want.color, want.last);
                        $display("         got x=%0d y=%0d vis=%0b addr=%h col=%h last=%0b",
                                 got.x, got.y, got.vis, got.addr, got.color, got.last);
                    end
                end
            end
        end
        rdy = 0;
        if (hold_cnt > 0) begin
            hold_cnt--;
        end else if (hold_reqs != holds_done) begin
            holds_done++;
            hold_cnt = LONG_HOLD;
        end else if (snk_gap > 0) begin
            snk_gap--;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            snk_gap = $urandom_range(0, 17);
        end else begin
            rdy = 1;
        end
        m_tready <= rdy;
    end

    task automatic reg_write(input reg_idx_t idx, input int unsigned val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_FRAME_WIDTH:  frame_w  = FW_W'(val);
            REG_FRAME_HEIGHT: frame_h  = FW_W'(val);
            REG_BYTES_PER_PX: px_bytes = BPP_W'(val);
            REG_ROW_PITCH:    pitch    = PITCH_W'(val);
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // all items taken, all pixels back, pipeline flushed of idle advances
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || pixels_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic push_load(input int xs, input int ys, input int xe, input int ye,
                             input logic [COLOR_W-1:0] c);
        line_item_t it;
        it.kind  = KIND_LOAD;
        it.xs    = coord_t'(xs);
        it.ys    = coord_t'(ys);
        it.xe    = coord_t'(xe);
        it.ye    = coord_t'(ye);
        it.color = c;
        pending_items.push_back(it);
    endtask

    // advance data fields are don't-care, so fill them with noise
    task automatic push_adv(input int n);
        line_item_t it;
        repeat (n) begin
            it.kind  = KIND_ADVANCE;
            it.xs    = coord_t'($urandom);
            it.ys    = coord_t'($urandom);
            it.xe    = coord_t'($urandom);
            it.ye    = coord_t'($urandom);
            it.color = COLOR_W'($urandom);
            pending_items.push_back(it);
        end
    endtask

    task automatic add_random_line();
        int sel, span, xs, ys, xe, ye, n, n_adv;
        sel  = $urandom_range(0, 99);
        span = (sel < 90) ? $urandom_range(0, 24) : $urandom_range(25, 400);
        if (sel < 70) begin
            // around either frame edge so clipping flips often
            xs = ($urandom_range(0, 1) ? int'(frame_w) : 0) + int'($urandom_range(0, 40)) - 20;
            ys = ($urandom_range(0, 1) ? int'(frame_h) : 0) + int'($urandom_range(0, 40)) - 20;
        end else begin
            xs = int'($urandom_range(0, 65535)) - 32768;
            ys = int'($urandom_range(0, 65535)) - 32768;
        end
        xe = xs + int'($urandom_range(0, 2 * span)) - span;
        ye = ys + int'($urandom_range(0, 2 * span)) - span;
        if (xe > 32767 || xe < -32768) xe = 2 * xs - xe;
        if (ye > 32767 || ye < -32768) ye = 2 * ys - ye;
        n = (xe > xs ? xe - xs : xs - xe);
        if ((ye > ys ? ye - ys : ys - ye) > n) n = (ye > ys ? ye - ys : ys - ye);
        sel   = $urandom_range(0, 9);
        // sometimes cut short by the next load
        n_adv = (sel == 0) ? $urandom_range(0, n) : n;
        push_load(xs, ys, xe, ye, COLOR_W'($urandom));
        push_adv(n_adv);
        if (sel == 1) push_adv($urandom_range(1, 3));
        phase_items += 1 + n_adv;
    endtask

    initial begin : stimulus
        int unsigned ph_fw[7]    = '{64, 1, 4096, 0, 8191, 100, 33};
        int unsigned ph_fh[7]    = '{48, 1, 4096, 5, 8191, 30, 200};
        int unsigned ph_bpp[7]   = '{1, 8, 8, 0, 15, 3, 2};
        int unsigned ph_pitch[7] = '{64, 1, 32768, 0, 65535, 300, 1000};
        int guard;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings
        push_adv(1);                                       // nothing loaded yet
        push_load(5, 5, 5, 5, 24'h123456);                 // single pixel
        push_adv(1);                                       // line already ended
        push_load(0, 0, 3, 0, 24'hffffff);                 // horizontal
        push_adv(3);
        push_load(2, 3, 2, 1, 24'h000000);                 // vertical, upwards
        push_adv(2);
        push_load(0, 0, 1, 3, 24'ha5a5a5);                 // steep
        push_adv(3);
        push_load(-32768, 32767, 32767, -32768, 24'hffffff);
        push_adv(2);
        push_load(32767, -32768, -32768, 32767, 24'h5a5a5a); // reload mid-walk
        push_adv(1);
        push_load(1022, 1023, 1025, 1023, 24'h0f0f0f);     // crosses right edge
        push_adv(3);
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            reg_write(REG_FRAME_WIDTH, ph_fw[p]);
            reg_write(REG_FRAME_HEIGHT, ph_fh[p]);
            reg_write(REG_BYTES_PER_PX, ph_bpp[p]);
            reg_write(REG_ROW_PITCH, ph_pitch[p]);
            quiet       = (p == 6);
            phase_items = 0;
            if (p == 5) begin
                // long line queued, then the receiver stops for a while
                push_load(-5, 0, 140, 40, 24'hc0ffee);
                push_adv(145);
                hold_reqs++;
            end
            while (phase_items < 140) add_random_line();
            wait_idle();
        end

        guard = 0;
        while (pixels_due.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        errors += pixels_due.size();

        $display("Run covered %0d loads and %0d advances (%0d with no line) over 8 frame settings.",
                 n_loads, n_advances, n_idle_adv);
        $display("%0d pixels predicted, %0d clipped, %0d line ends; %0d errors.",
                 n_pixels, n_clipped, n_ends, errors);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
